[rtl/core/vcid_pkg.sv]
// ----------------------------------------------------------------------------
// vcid_pkg
// Shared types, field codes, mnemonic ids and lookup tables for the
// vector-coprocessor instruction decoder.
// ----------------------------------------------------------------------------
package vcid_pkg;

  localparam int WORD_W  = 32;
  localparam int ID_W    = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [ID_W-1:0] instr_id_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BRANCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BEQZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BNEZ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NOT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEGU   = 3'd6;

  // pseudo-instruction rename enables
  typedef struct packed {
    logic ren_all;
    logic ren_b;
    logic ren_beqz;
    logic ren_bnez;
    logic ren_move;
    logic ren_not;
    logic ren_negu;
  } ren_cfg_t;

  localparam ren_cfg_t REN_CFG_RESET = '{default: 1'b1};

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_VLOAD   = 6'b110010;
  localparam logic [5:0] OP_VSTORE  = 6'b111010;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BLTZAL = 5'h10;
  localparam logic [4:0] RT_BGEZAL = 5'h11;

  // cop0 rs codes
  localparam logic [4:0] RS_MF = 5'h00;
  localparam logic [4:0] RS_MT = 5'h04;

  // cop2 move codes in element-high
  localparam logic [3:0] EHI_MF = 4'h0;
  localparam logic [3:0] EHI_MT = 4'h4;
  localparam logic [3:0] EHI_CF = 4'h2;
  localparam logic [3:0] EHI_CT = 4'h6;

  localparam logic [4:0] RA_REG     = 5'd31;
  localparam logic [4:0] RD_VSTORE_U = 5'b00111;

  // mnemonic ids
  localparam instr_id_t ID_INVALID = 8'd0;
  localparam instr_id_t ID_BEQ     = 8'd3;
  localparam instr_id_t ID_BNE     = 8'd4;
  localparam instr_id_t ID_SUV     = 8'd34;
  localparam instr_id_t ID_SWV     = 8'd35;
  localparam instr_id_t ID_B       = 8'd50;
  localparam instr_id_t ID_BEQZ    = 8'd51;
  localparam instr_id_t ID_BNEZ    = 8'd52;
  localparam instr_id_t ID_JALR    = 8'd60;
  localparam instr_id_t ID_SUBU    = 8'd67;
  localparam instr_id_t ID_OR      = 8'd69;
  localparam instr_id_t ID_NOR     = 8'd71;
  localparam instr_id_t ID_NOP     = 8'd74;
  localparam instr_id_t ID_MOVE    = 8'd75;
  localparam instr_id_t ID_NOT     = 8'd76;
  localparam instr_id_t ID_NEGU    = 8'd77;
  localparam instr_id_t ID_BLTZ    = 8'd78;
  localparam instr_id_t ID_BGEZ    = 8'd79;
  localparam instr_id_t ID_BLTZAL  = 8'd80;
  localparam instr_id_t ID_BGEZAL  = 8'd81;
  localparam instr_id_t ID_MFC0    = 8'd82;
  localparam instr_id_t ID_MTC0    = 8'd83;
  localparam instr_id_t ID_MFC2    = 8'd84;
  localparam instr_id_t ID_MTC2    = 8'd85;
  localparam instr_id_t ID_CFC2    = 8'd86;
  localparam instr_id_t ID_CTC2    = 8'd87;
  localparam instr_id_t ID_VNOP    = 8'd131;

  function automatic instr_id_t main_lookup(input logic [5:0] op);
    case (op)
      6'h02: main_lookup = 8'd1;
      6'h03: main_lookup = 8'd2;
      6'h04: main_lookup = ID_BEQ;
      6'h05: main_lookup = ID_BNE;
      6'h06: main_lookup = 8'd5;
      6'h07: main_lookup = 8'd6;
      6'h08: main_lookup = 8'd7;
      6'h09: main_lookup = 8'd8;
      6'h0A: main_lookup = 8'd9;
      6'h0B: main_lookup = 8'd10;
      6'h0C: main_lookup = 8'd11;
      6'h0D: main_lookup = 8'd12;
      6'h0E: main_lookup = 8'd13;
      6'h0F: main_lookup = 8'd14;
      6'h20: main_lookup = 8'd15;
      6'h21: main_lookup = 8'd16;
      6'h23: main_lookup = 8'd17;
      6'h24: main_lookup = 8'd18;
      6'h25: main_lookup = 8'd19;
      6'h28: main_lookup = 8'd20;
      6'h29: main_lookup = 8'd21;
      6'h2B: main_lookup = 8'd22;
      6'h2F: main_lookup = 8'd23;
      6'h31: main_lookup = 8'd24;
      6'h33: main_lookup = 8'd25;
      6'h39: main_lookup = 8'd26;
      default: main_lookup = ID_INVALID;
    endcase
  endfunction

  function automatic instr_id_t vstore_lookup(input logic [4:0] rd);
    case (rd)
      5'd0:  vstore_lookup = 8'd27;
      5'd1:  vstore_lookup = 8'd28;
      5'd2:  vstore_lookup = 8'd29;
      5'd3:  vstore_lookup = 8'd30;
      5'd4:  vstore_lookup = 8'd31;
      5'd5:  vstore_lookup = 8'd32;
      5'd6:  vstore_lookup = 8'd33;
      5'd7:  vstore_lookup = ID_SUV;
      5'd8:  vstore_lookup = 8'd36;
      5'd9:  vstore_lookup = 8'd37;
      5'd11: vstore_lookup = 8'd38;
      default: vstore_lookup = ID_INVALID;
    endcase
  endfunction

  function automatic instr_id_t vload_lookup(input logic [4:0] rd);
    case (rd)
      5'd0:  vload_lookup = 8'd39;
      5'd1:  vload_lookup = 8'd40;
      5'd2:  vload_lookup = 8'd41;
      5'd3:  vload_lookup = 8'd42;
      5'd4:  vload_lookup = 8'd43;
      5'd5:  vload_lookup = 8'd44;
      5'd6:  vload_lookup = 8'd45;
      5'd7:  vload_lookup = 8'd46;
      5'd8:  vload_lookup = 8'd47;
      5'd9:  vload_lookup = 8'd48;
      5'd11: vload_lookup = 8'd49;
      default: vload_lookup = ID_INVALID;
    endcase
  endfunction

  function automatic instr_id_t special_lookup(input logic [5:0] fn);
    case (fn)
      6'h00: special_lookup = 8'd53;
      6'h02: special_lookup = 8'd54;
      6'h03: special_lookup = 8'd55;
      6'h04: special_lookup = 8'd56;
      6'h06: special_lookup = 8'd57;
      6'h07: special_lookup = 8'd58;
      6'h08: special_lookup = 8'd59;
      6'h09: special_lookup = ID_JALR;
      6'h0A: special_lookup = 8'd61;
      6'h0B: special_lookup = 8'd62;
      6'h0D: special_lookup = 8'd63;
      6'h20: special_lookup = 8'd64;
      6'h21: special_lookup = 8'd65;
      6'h22: special_lookup = 8'd66;
      6'h23: special_lookup = ID_SUBU;
      6'h24: special_lookup = 8'd68;
      6'h25: special_lookup = ID_OR;
      6'h26: special_lookup = 8'd70;
      6'h27: special_lookup = ID_NOR;
      6'h2A: special_lookup = 8'd72;
      6'h2B: special_lookup = 8'd73;
      default: special_lookup = ID_INVALID;
    endcase
  endfunction

  function automatic instr_id_t vec_lookup(input logic [5:0] fn);
    case (fn)
      6'h00: vec_lookup = 8'd88;
      6'h01: vec_lookup = 8'd89;
      6'h02: vec_lookup = 8'd90;
      6'h03: vec_lookup = 8'd91;
      6'h04: vec_lookup = 8'd92;
      6'h05: vec_lookup = 8'd93;
      6'h06: vec_lookup = 8'd94;
      6'h07: vec_lookup = 8'd95;
      6'h08: vec_lookup = 8'd96;
      6'h09: vec_lookup = 8'd97;
      6'h0A: vec_lookup = 8'd98;
      6'h0B: vec_lookup = 8'd99;
      6'h0C: vec_lookup = 8'd100;
      6'h0D: vec_lookup = 8'd101;
      6'h0E: vec_lookup = 8'd102;
      6'h0F: vec_lookup = 8'd103;
      6'h10: vec_lookup = 8'd104;
      6'h11: vec_lookup = 8'd105;
      6'h13: vec_lookup = 8'd106;
      6'h14: vec_lookup = 8'd107;
      6'h15: vec_lookup = 8'd108;
      6'h1D: vec_lookup = 8'd109;
      6'h28: vec_lookup = 8'd110;
      6'h29: vec_lookup = 8'd111;
      6'h2A: vec_lookup = 8'd112;
      6'h2B: vec_lookup = 8'd113;
      6'h2C: vec_lookup = 8'd114;
      6'h2D: vec_lookup = 8'd115;
      6'h20: vec_lookup = 8'd116;
      6'h21: vec_lookup = 8'd117;
      6'h22: vec_lookup = 8'd118;
      6'h23: vec_lookup = 8'd119;
      6'h24: vec_lookup = 8'd120;
      6'h25: vec_lookup = 8'd121;
      6'h26: vec_lookup = 8'd122;
      6'h27: vec_lookup = 8'd123;
      6'h30: vec_lookup = 8'd124;
      6'h31: vec_lookup = 8'd125;
      6'h32: vec_lookup = 8'd126;
      6'h33: vec_lookup = 8'd127;
      6'h34: vec_lookup = 8'd128;
      6'h35: vec_lookup = 8'd129;
      6'h36: vec_lookup = 8'd130;
      6'h37: vec_lookup = ID_VNOP;
      default: vec_lookup = ID_INVALID;
    endcase
  endfunction

endpackage

[rtl/core/vcid_cfg_regs.sv]
// ----------------------------------------------------------------------------
// vcid_cfg_regs
// Rename-enable register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module vcid_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vcid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  output vcid_pkg::ren_cfg_t            ren_cfg
);
  import vcid_pkg::*;

  ren_cfg_t cfg_r;
  ren_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign ren_cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_ENABLE: cfg_nxt.ren_all  = cfg_data;
        CFG_IDX_BRANCH: cfg_nxt.ren_b    = cfg_data;
        CFG_IDX_BEQZ:   cfg_nxt.ren_beqz = cfg_data;
        CFG_IDX_BNEZ:   cfg_nxt.ren_bnez = cfg_data;
        CFG_IDX_MOVE:   cfg_nxt.ren_move = cfg_data;
        CFG_IDX_NOT:    cfg_nxt.ren_not  = cfg_data;
        CFG_IDX_NEGU:   cfg_nxt.ren_negu = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= REN_CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/vcid_decode.sv]
// ----------------------------------------------------------------------------
// vcid_decode
// Combinational decode of one instruction word into a mnemonic id and the
// jalr custom-destination flag, including pseudo-instruction renames.
// ----------------------------------------------------------------------------
module vcid_decode (
  input  logic [vcid_pkg::WORD_W-1:0] word,
  input  vcid_pkg::ren_cfg_t          ren_cfg,
  output vcid_pkg::instr_id_t         instr_id,
  output logic                        jalr_custom_dest
);
  import vcid_pkg::*;

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [5:0] fn;
  logic [3:0] ehi;
  logic [3:0] elo;
  instr_id_t  base_id;
  instr_id_t  mem_id;

  assign op  = word[31:26];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign rd  = word[15:11];
  assign fn  = word[5:0];
  assign ehi = word[24:21];
  assign elo = word[10:7];

  assign base_id = special_lookup(fn);

  // immediate-class opcodes: vector load/store by rd, the rest by opcode
  always_comb begin
    if (op == OP_VSTORE) begin
      mem_id = vstore_lookup(rd);
      if (mem_id == ID_SUV && elo != 4'd0) begin
        mem_id = ID_SWV;
      end
    end else if (op == OP_VLOAD) begin
      mem_id = vload_lookup(rd);
    end else begin
      mem_id = main_lookup(op);
    end
  end

  always_comb begin
    instr_id         = ID_INVALID;
    jalr_custom_dest = 1'b0;
    case (op)
      OP_SPECIAL: begin
        instr_id = base_id;
        if (word == '0) begin
          instr_id = ID_NOP;
        end else if (ren_cfg.ren_all) begin
          if (rt == 5'd0) begin
            if (base_id == ID_OR && ren_cfg.ren_move) begin
              instr_id = ID_MOVE;
            end else if (base_id == ID_NOR && ren_cfg.ren_not) begin
              instr_id = ID_NOT;
            end
          end else if (base_id == ID_SUBU && rs == 5'd0 && ren_cfg.ren_negu) begin
            instr_id = ID_NEGU;
          end
        end
        jalr_custom_dest = (base_id == ID_JALR) && (word != '0) && (rd != RA_REG);
      end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ:   instr_id = ID_BLTZ;
          RT_BGEZ:   instr_id = ID_BGEZ;
          RT_BLTZAL: instr_id = ID_BLTZAL;
          RT_BGEZAL: instr_id = ID_BGEZAL;
          default:   instr_id = ID_INVALID;
        endcase
      end
      OP_COP0: begin
        case (rs)
          RS_MF:   instr_id = ID_MFC0;
          RS_MT:   instr_id = ID_MTC0;
          default: instr_id = ID_INVALID;
        endcase
      end
      OP_COP2: begin
        if (!word[25]) begin
          case (ehi)
            EHI_MF:  instr_id = ID_MFC2;
            EHI_MT:  instr_id = ID_MTC2;
            EHI_CF:  instr_id = ID_CFC2;
            EHI_CT:  instr_id = ID_CTC2;
            default: instr_id = ID_INVALID;
          endcase
        end else begin
          instr_id = vec_lookup(fn);
        end
      end
      default: begin
        instr_id = mem_id;
        if (ren_cfg.ren_all && rt == 5'd0) begin
          if (mem_id == ID_BEQ) begin
            if (rs == 5'd0) begin
              if (ren_cfg.ren_b) begin
                instr_id = ID_B;
              end
            end else if (ren_cfg.ren_beqz) begin
              instr_id = ID_BEQZ;
            end
          end else if (mem_id == ID_BNE && ren_cfg.ren_bnez) begin
            instr_id = ID_BNEZ;
          end
        end
      end
    endcase
  end

endmodule

[rtl/core/vector_coprocessor_instruction_decoder_top.sv]
// ----------------------------------------------------------------------------
// vector_coprocessor_instruction_decoder_top
// Registered decoder for vector-coprocessor instruction words: input
// register, shallow case decode, result register.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | in_instr_word
//   out     | out       | out_valid/out_ready  | out_instr_id, out_jalr_custom_dest
//
// one word per cycle sustained while out_ready stays high; a word taken at the
// input passes the input register, decode and result register to the output
// in_ready drops only while both registers hold words and out_ready is low
// configuration writes are taken every cycle; rename enables reset to 1
// synchronous active-low reset empties both stages
// ----------------------------------------------------------------------------
module vector_coprocessor_instruction_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vcid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vcid_pkg::WORD_W-1:0]    in_instr_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vcid_pkg::ID_W-1:0]      out_instr_id,
  output logic                           out_jalr_custom_dest
);
  import vcid_pkg::*;

  ren_cfg_t          ren_cfg;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [WORD_W-1:0] s1_word_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  instr_id_t         out_id_r;
  logic              out_flag_r;
  instr_id_t         dec_id;
  logic              dec_flag;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  vcid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ren_cfg   (ren_cfg)
  );

  vcid_decode u_dec (
    .word             (s1_word_r),
    .ren_cfg          (ren_cfg),
    .instr_id         (dec_id),
    .jalr_custom_dest (dec_flag)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_instr_word;
    end
    if (s1_adv) begin
      out_id_r   <= dec_id;
      out_flag_r <= dec_flag;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_instr_id         = out_id_r;
  assign out_jalr_custom_dest = out_flag_r;

`ifndef SYNTHESIS
  a_flag_only_jalr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jalr_custom_dest |-> out_instr_id == ID_JALR)
    else $error("custom-destination flag on a non-jalr result");

  a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_instr_id <= ID_VNOP)
    else $error("decoded id out of range");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("decoded word lost between stages");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  a_cfg_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> ren_cfg == REN_CFG_RESET)
    else $error("rename enables not set after reset");
`endif

endmodule

[tb/sv/vector_coprocessor_instruction_decoder_top_tb.sv]
// ----------------------------------------------------------------------------
// vector_coprocessor_instruction_decoder_top_tb
// Checks the instruction decoder against a behavioral decode written here.
// Each accepted word is decoded with the current rename enables and the
// result is queued. Every output transaction is compared with the oldest
// queued result. Directed words come first, then the rename controls,
// then back-pressure and random streams under several configurations.
// ----------------------------------------------------------------------------
module vector_coprocessor_instruction_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcid_pkg::*;

  localparam int RESET_CYCLES     = 10;
  localparam int PIPE_LATENCY     = 2;
  localparam int SETTLE_CYCLES    = PIPE_LATENCY + 1;
  localparam int QUIET_LIMIT      = 400;
  localparam int RANDOM_PHASES    = 6;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int MAX_PRINTED      = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_UNDEF = 6'h11;
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_VADD  = 6'h10;
  localparam logic [5:0] FN_VNOP  = 6'h37;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    instr_id_t         id;
    logic              jalr_far;
  } decoded_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic              cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] in_instr_word;
  logic              out_valid;
  logic              out_ready;
  logic [ID_W-1:0]   out_instr_id;
  logic              out_jalr_custom_dest;

  logic [6:0] rename_en;
  decoded_t   pending_decodes[$];
  int         error_count   = 0;
  int         quiet_cycles  = 0;
  int         hold_request  = 0;
  logic       no_idle       = 1'b0;

  vector_coprocessor_instruction_decoder_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_instr_word        (in_instr_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_instr_id         (out_instr_id),
    .out_jalr_custom_dest (out_jalr_custom_dest)
  );

  always #5 clk = ~clk;

  function automatic logic [WORD_W-1:0] make_word(input logic [5:0] op, input logic [4:0] rs,
                                                  input logic [4:0] rt, input logic [4:0] rd,
                                                  input logic [10:0] low);
    make_word = {op, rs, rt, rd, low};
  endfunction

  function automatic decoded_t decode_word(input logic [WORD_W-1:0] w);
    decoded_t   d;
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [3:0] ehi;
    logic [3:0] elo;
    op  = w[31:26];
    rs  = w[25:21];
    rt  = w[20:16];
    rd  = w[15:11];
    fn  = w[5:0];
    ehi = w[24:21];
    elo = w[10:7];
    d.word     = w;
    d.id       = ID_INVALID;
    d.jalr_far = 1'b0;
    case (op)
      OP_SPECIAL: begin
        if (fn[5:3] == 3'b100) begin
          d.id = instr_id_t'(fn[2:0]) + 8'd64;
        end else begin
          case (fn)
            6'h00: d.id = 8'd53;
            6'h02: d.id = 8'd54;
            6'h03: d.id = 8'd55;
            6'h04: d.id = 8'd56;
            6'h06: d.id = 8'd57;
            6'h07: d.id = 8'd58;
            6'h08: d.id = 8'd59;
            6'h09: d.id = ID_JALR;
            6'h0A: d.id = 8'd61;
            6'h0B: d.id = 8'd62;
            6'h0D: d.id = 8'd63;
            6'h2A: d.id = 8'd72;
            6'h2B: d.id = 8'd73;
            default: d.id = ID_INVALID;
          endcase
        end
        // the all-zero word wins over sll and every rename
        if (w == '0) begin
          d.id = ID_NOP;
        end else if (rename_en[CFG_IDX_ENABLE]) begin
          if (rt == 5'd0) begin
            if (d.id == ID_OR && rename_en[CFG_IDX_MOVE]) d.id = ID_MOVE;
            else if (d.id == ID_NOR && rename_en[CFG_IDX_NOT]) d.id = ID_NOT;
          end else if (d.id == ID_SUBU && rs == 5'd0 && rename_en[CFG_IDX_NEGU]) begin
            d.id = ID_NEGU;
          end
        end
        d.jalr_far = (d.id == ID_JALR) && (rd != RA_REG);
      end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ:   d.id = ID_BLTZ;
          RT_BGEZ:   d.id = ID_BGEZ;
          RT_BLTZAL: d.id = ID_BLTZAL;
          RT_BGEZAL: d.id = ID_BGEZAL;
          default:   d.id = ID_INVALID;
        endcase
      end
      OP_COP0: begin
        if (rs == RS_MF) d.id = ID_MFC0;
        else if (rs == RS_MT) d.id = ID_MTC0;
      end
      OP_COP2: begin
        if (!w[25]) begin
          case (ehi)
            EHI_MF:  d.id = ID_MFC2;
            EHI_MT:  d.id = ID_MTC2;
            EHI_CF:  d.id = ID_CFC2;
            EHI_CT:  d.id = ID_CTC2;
            default: d.id = ID_INVALID;
          endcase
        end else if (fn < 6'h10) begin
          d.id = instr_id_t'(fn) + 8'd88;
        end else begin
          case (fn[5:3])
            3'b100: d.id = instr_id_t'(fn[2:0]) + 8'd116;
            3'b110: d.id = instr_id_t'(fn[2:0]) + 8'd124;
            3'b101: d.id = (fn[2:1] == 2'b11) ? ID_INVALID : instr_id_t'(fn[2:0]) + 8'd110;
            default: begin
              case (fn)
                6'h10: d.id = 8'd104;
                6'h11: d.id = 8'd105;
                6'h13: d.id = 8'd106;
                6'h14: d.id = 8'd107;
                6'h15: d.id = 8'd108;
                6'h1D: d.id = 8'd109;
                default: d.id = ID_INVALID;
              endcase
            end
          endcase
        end
      end
      default: begin
        if (op == OP_VSTORE) begin
          if (rd < RD_VSTORE_U) d.id = instr_id_t'(rd) + 8'd27;
          else if (rd == RD_VSTORE_U) d.id = (elo == 4'd0) ? ID_SUV : ID_SWV;
          else if (rd == 5'd8) d.id = 8'd36;
          else if (rd == 5'd9) d.id = 8'd37;
          else if (rd == 5'd11) d.id = 8'd38;
        end else if (op == OP_VLOAD) begin
          if (rd <= 5'd9) d.id = instr_id_t'(rd) + 8'd39;
          else if (rd == 5'd11) d.id = 8'd49;
        end else if (op >= 6'h02 && op <= 6'h0F) begin
          d.id = instr_id_t'(op) - 8'd1;
        end else begin
          case (op)
            6'h20: d.id = 8'd15;
            6'h21: d.id = 8'd16;
            6'h23: d.id = 8'd17;
            6'h24: d.id = 8'd18;
            6'h25: d.id = 8'd19;
            6'h28: d.id = 8'd20;
            6'h29: d.id = 8'd21;
            6'h2B: d.id = 8'd22;
            6'h2F: d.id = 8'd23;
            6'h31: d.id = 8'd24;
            6'h33: d.id = 8'd25;
            6'h39: d.id = 8'd26;
            default: d.id = ID_INVALID;
          endcase
        end
        if (rename_en[CFG_IDX_ENABLE] && rt == 5'd0) begin
          if (d.id == ID_BEQ) begin
            // with both registers zero only the branch rename applies
            if (rs == 5'd0) begin
              if (rename_en[CFG_IDX_BRANCH]) d.id = ID_B;
            end else if (rename_en[CFG_IDX_BEQZ]) begin
              d.id = ID_BEQZ;
            end
          end else if (d.id == ID_BNE && rename_en[CFG_IDX_BNEZ]) begin
            d.id = ID_BNEZ;
          end
        end
      end
    endcase
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;
      2: w[31:26] = OP_SPECIAL;
      3: begin
        w[31:26] = OP_SPECIAL;
        case ($urandom_range(0, 3))
          0: w[5:0] = FN_OR;
          1: w[5:0] = FN_NOR;
          2: w[5:0] = FN_SUBU;
          default: w[5:0] = FN_JALR;
        endcase
        if ($urandom_range(0, 1)) w[20:16] = '0;
        if ($urandom_range(0, 1)) w[25:21] = '0;
        if ($urandom_range(0, 3) == 0) w[15:11] = RA_REG;
        if ($urandom_range(0, 15) == 0) w = '0;
      end
      4: begin
        w[31:26] = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
        if ($urandom_range(0, 3) != 0) w[20:16] = '0;
        if ($urandom_range(0, 1)) w[25:21] = '0;
      end
      5: begin
        w[31:26] = OP_REGIMM;
        if ($urandom_range(0, 3) != 0) begin
          w[20]    = 1'($urandom_range(0, 1));
          w[19:17] = '0;
          w[16]    = 1'($urandom_range(0, 1));
        end
      end
      6: begin
        w[31:26] = OP_COP0;
        if ($urandom_range(0, 3) != 0) w[25:21] = $urandom_range(0, 1) ? RS_MF : RS_MT;
      end
      7: begin
        w[31:26] = OP_COP2;
        if ($urandom_range(0, 2) == 0) begin
          w[25] = 1'b0;
          if ($urandom_range(0, 3) != 0) begin
            w[24] = 1'b0;
            w[21] = 1'b0;
          end
        end
      end
      8: begin
        w[31:26] = $urandom_range(0, 1) ? OP_VLOAD : OP_VSTORE;
        w[15:11] = 5'($urandom_range(0, 12));
        if ($urandom_range(0, 1)) w[10:7] = '0;
      end
      default: begin
        w[31:26] = 6'($urandom_range(2, 15));
        if ($urandom_range(0, 1)) w[20:16] = '0;
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] word,
                                 input int unsigned want, input int unsigned got);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch %s: word %h expected %0d got %0d", $realtime, what, word,
               want, got);
    error_count++;
  endtask

  // one input transaction; called at a rising edge, returns at the accepting edge
  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_instr_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_decodes.push_back(decode_word(w));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_IDX_NEGU) rename_en[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  // bit positions follow the register indexes
  task automatic apply_rename_cfg(input logic [6:0] bits);
    write_cfg(CFG_IDX_ENABLE, bits[CFG_IDX_ENABLE]);
    write_cfg(CFG_IDX_BRANCH, bits[CFG_IDX_BRANCH]);
    write_cfg(CFG_IDX_BEQZ, bits[CFG_IDX_BEQZ]);
    write_cfg(CFG_IDX_BNEZ, bits[CFG_IDX_BNEZ]);
    write_cfg(CFG_IDX_MOVE, bits[CFG_IDX_MOVE]);
    write_cfg(CFG_IDX_NOT, bits[CFG_IDX_NOT]);
    write_cfg(CFG_IDX_NEGU, bits[CFG_IDX_NEGU]);
  endtask

  task automatic send_rename_words();
    send_word(make_word(OP_BEQ, 5'd0, 5'd0, 5'd0, 11'h010));
    send_word(make_word(OP_BEQ, 5'd9, 5'd0, 5'd31, 11'h7FF));
    send_word(make_word(OP_BNE, 5'd3, 5'd0, 5'd1, 11'h123));
    send_word(make_word(OP_SPECIAL, 5'd4, 5'd0, 5'd8, {5'd0, FN_OR}));
    send_word(make_word(OP_SPECIAL, 5'd6, 5'd0, 5'd2, {5'd0, FN_NOR}));
    send_word(make_word(OP_SPECIAL, 5'd0, 5'd7, 5'd5, {5'd0, FN_SUBU}));
  endtask

  task automatic test_directed_decode();
    send_word('0);
    send_word('1);
    send_word(make_word(OP_SPECIAL, 5'd0, 5'd0, 5'd0, {5'd1, FN_SLL}));
    send_word(make_word(OP_SPECIAL, 5'd3, 5'd0, RA_REG, {5'd0, FN_JALR}));
    send_word(make_word(OP_SPECIAL, 5'd3, 5'd0, 5'd5, {5'd0, FN_JALR}));
    send_word(make_word(OP_REGIMM, 5'd1, RT_BLTZ, 5'd0, 11'h001));
    send_word(make_word(OP_REGIMM, 5'd1, RT_BGEZ, 5'd0, 11'h002));
    send_word(make_word(OP_REGIMM, 5'd1, RT_BLTZAL, 5'd0, 11'h003));
    send_word(make_word(OP_REGIMM, 5'd1, RT_BGEZAL, 5'd0, 11'h004));
    send_word(make_word(OP_REGIMM, 5'd1, 5'h1F, 5'd0, 11'h005));
    send_word(make_word(OP_COP0, RS_MF, 5'd2, 5'd12, 11'h000));
    send_word(make_word(OP_COP0, RS_MT, 5'd2, 5'd12, 11'h000));
    send_word(make_word(OP_COP2, {1'b0, EHI_MF}, 5'd1, 5'd2, 11'h080));
    send_word(make_word(OP_COP2, {1'b0, EHI_MT}, 5'd1, 5'd2, 11'h080));
    send_word(make_word(OP_COP2, {1'b0, EHI_CF}, 5'd1, 5'd2, 11'h080));
    send_word(make_word(OP_COP2, {1'b0, EHI_CT}, 5'd1, 5'd2, 11'h080));
    send_word(make_word(OP_COP2, 5'h13, 5'd4, 5'd5, {5'd6, FN_VADD}));
    send_word(make_word(OP_COP2, 5'h10, 5'd0, 5'd0, {5'd0, FN_VNOP}));
    // vector store with rd 7 splits on element-low
    send_word(make_word(OP_VSTORE, 5'd2, 5'd4, RD_VSTORE_U, {4'h0, 7'h15}));
    send_word(make_word(OP_VSTORE, 5'd2, 5'd4, RD_VSTORE_U, {4'hF, 7'h15}));
    send_word(make_word(OP_VSTORE, 5'd2, 5'd4, 5'd10, 11'h000));
    send_word(make_word(OP_VLOAD, 5'd2, 5'd4, 5'd11, 11'h040));
    send_word(make_word(OP_UNDEF, 5'd0, 5'd0, 5'd0, 11'h000));
  endtask

  task automatic test_rename_controls();
    for (int k = 0; k < 7; k++) begin
      apply_rename_cfg(~(7'd1 << k));
      send_rename_words();
    end
    apply_rename_cfg('0);
    send_rename_words();
    apply_rename_cfg('1);
    // no register behind this index, renames must stay on
    write_cfg(CFG_IDX_UNUSED, 1'b0);
    send_rename_words();
  endtask

  task automatic test_backpressure();
    wait_for_results();
    hold_request = 40;
    no_idle      = 1'b1;
    repeat (30) send_word(random_word());
    no_idle = 1'b0;
    wait_for_results();
    repeat (20) send_word(random_word());
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_rename_cfg('1);
        1: apply_rename_cfg('0);
        default: apply_rename_cfg(7'($urandom_range(0, 127)));
      endcase
      no_idle = (phase == RANDOM_PHASES - 1);
      repeat (RANDOM_PER_PHASE) send_word(random_word());
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("transaction with nothing pending", '0, 0, 32'(out_instr_id));
      end else begin
        want = pending_decodes.pop_front();
        if (out_instr_id !== want.id)
          report_mismatch("instr_id", want.word, 32'(want.id), 32'(out_instr_id));
        if (out_jalr_custom_dest !== want.jalr_far)
          report_mismatch("jalr_custom_dest", want.word, 32'(want.jalr_far),
                          32'(out_jalr_custom_dest));
      end
    end
  end

  // stall watchdog: any accepted transaction restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = 1'b0;
    in_valid      = 1'b0;
    in_instr_word = '0;
    rename_en     = '1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_decode();
    test_rename_controls();
    test_backpressure();
    test_random_streams();
    wait_for_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
